// File: sv/grid_ray_march_wall_hit_macros.svh
// Assertion macros used by the block's datapath module.
`ifndef GRID_RAY_MARCH_WALL_HIT_MACROS_SVH
`define GRID_RAY_MARCH_WALL_HIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GRMWH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GRMWH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/grmwh_pkg.sv
package grmwh_pkg;

  // Map and angle geometry
  localparam int MAP_DIM     = 64;
  localparam int CELL_SHIFT  = 6;
  localparam int ANGLE_STEPS = 1024;
  localparam int FRAC_BITS   = 14;

  localparam int MAP_W     = $clog2(MAP_DIM);
  localparam int ADDR_W    = 2 * MAP_W;
  localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
  localparam int ANGLE_W   = $clog2(ANGLE_STEPS);
  localparam int QUARTER   = ANGLE_STEPS / 4;
  localparam int QTR_W     = ANGLE_W - 2;

  // Fixed field widths
  localparam int OP_W       = 1;
  localparam int CELL_IDX_W = 6;
  localparam int ANGLE_IN_W = 10;
  localparam int LEN_W      = 16;
  localparam int FACE_W     = 2;
  localparam int TEX_W      = 6;
  localparam int PLAYER_W   = 26;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;

  localparam logic [STEP_W-1:0] MAX_STEPS_RESET = 16'd4096;

  // Direction vector: Q1.14 magnitude up to 1.0, signed
  localparam int SIN_MAG_W = FRAC_BITS + 1;
  localparam int DIR_W     = SIN_MAG_W + 1;

  // Position: signed Q.14 with room for one step outside the map
  localparam int POS_BASE = MAP_W + CELL_SHIFT + FRAC_BITS + 2;
  localparam int POS_W    = (POS_BASE > PLAYER_W + 2) ? POS_BASE : PLAYER_W + 2;
  localparam int CELL_W   = POS_W - FRAC_BITS - CELL_SHIFT;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam int unsigned TAYLOR_DIV [0:5] = '{6, 20, 42, 72, 110, 156};

  typedef logic signed [DIR_W-1:0]  dir_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [CELL_W-1:0] cell_t;
  typedef logic [QUARTER-1:0][SIN_MAG_W-1:0] sin_tab_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_EAST  = 2'd2,
    FACE_WEST  = 2'd3
  } face_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_CELL = 1'b0,
    OP_CAST       = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAYER_X  = 2'd0,
    REG_PLAYER_Y  = 2'd1,
    REG_MAX_STEPS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic clear;
    logic cell_write;
    logic start;
    logic step;
    logic set_timeout;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic blocked;
    logic at_limit;
    logic out_busy;
  } ctl_status_t;

  // First-quadrant sine, Taylor series to x^13 in Q2.30, rounded to Q1.14.
  // Evaluated at elaboration only.
  function automatic logic [SIN_MAG_W-1:0] quarter_sin(input int unsigned r);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(r) * TWO_PI_Q30) / ANGLE_STEPS;
    term = x;
    sum  = x;
    for (int n = 0; n < 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n];
      if (n % 2 == 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'd32768) >> 16;
    if (sum > 64'd16384) begin
      sum = 64'd16384;
    end
    return SIN_MAG_W'(sum);
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int i = 0; i < QUARTER; i++) begin
      tab[i] = quarter_sin(i);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();
  localparam logic [SIN_MAG_W-1:0] SIN_PEAK = quarter_sin(QUARTER);

  // Full-circle sine by quadrant symmetry
  function automatic dir_t sin_lookup(input logic [ANGLE_W-1:0] v);
    logic [QTR_W-1:0]     r;
    logic [QTR_W-1:0]     rr;
    logic [SIN_MAG_W-1:0] mag;
    dir_t                 val;
    r  = v[QTR_W-1:0];
    rr = '0 - r;
    if (v[ANGLE_W-2]) begin
      mag = (r == '0) ? SIN_PEAK : SIN_TAB[rr];
    end else begin
      mag = SIN_TAB[r];
    end
    val = dir_t'({1'b0, mag});
    if (v[ANGLE_W-1]) begin
      val = -val;
    end
    return val;
  endfunction

  // Floor of position over the cell size: the upper bits in two's complement
  function automatic cell_t cell_of(input pos_t p);
    return p[POS_W-1:FRAC_BITS+CELL_SHIFT];
  endfunction

  function automatic logic cell_oob(input cell_t c);
    return c[CELL_W-1:MAP_W] != '0;
  endfunction

  function automatic logic [ADDR_W-1:0] map_addr(input logic [MAP_W-1:0] row,
                                                 input logic [MAP_W-1:0] col);
    return {row, col};
  endfunction

endpackage

// File: sv/grmwh_if.sv
interface grmwh_in_if;
  import grmwh_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [CELL_IDX_W-1:0] cell_col;
  logic [CELL_IDX_W-1:0] cell_row;
  logic                  cell_wall;
  logic [ANGLE_IN_W-1:0] ray_angle;
  modport source (output valid, operation, cell_col, cell_row, cell_wall, ray_angle,
                  input ready);
  modport sink (input valid, operation, cell_col, cell_row, cell_wall, ray_angle,
                output ready);
endinterface

interface grmwh_out_if;
  import grmwh_pkg::*;
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  ray_length;
  logic [FACE_W-1:0] wall_face;
  logic [TEX_W-1:0]  tex_column;
  logic              timed_out;
  modport source (output valid, ray_length, wall_face, tex_column, timed_out,
                  input ready);
  modport sink (input valid, ray_length, wall_face, tex_column, timed_out,
                output ready);
endinterface

interface grmwh_cfg_if;
  import grmwh_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/grmwh_ram.sv
module grmwh_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/grmwh_ctrl.sv
module grmwh_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_op,
  output logic                  in_ready,
  input  grmwh_pkg::ctl_status_t status,
  output grmwh_pkg::ctl_cmd_t   cmd
);
  import grmwh_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_MARCH  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_CAST) begin
            cmd.start  = 1'b1;
            state_next = ST_MARCH;
          end else begin
            cmd.cell_write = 1'b1;
          end
        end
      end
      ST_MARCH: begin
        if (status.blocked) begin
          state_next = ST_FINISH;
        end else if (status.at_limit) begin
          cmd.set_timeout = 1'b1;
          state_next      = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: sv/grmwh_datapath.sv
`include "grid_ray_march_wall_hit_macros.svh"

module grmwh_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  grmwh_pkg::ctl_cmd_t                 cmd,
  output grmwh_pkg::ctl_status_t              status,
  input  logic [grmwh_pkg::CELL_IDX_W-1:0]    cell_col,
  input  logic [grmwh_pkg::CELL_IDX_W-1:0]    cell_row,
  input  logic                                cell_wall,
  input  logic [grmwh_pkg::ANGLE_IN_W-1:0]    ray_angle,
  grmwh_cfg_if.sink                           cfg,
  grmwh_out_if.source                         result
);
  import grmwh_pkg::*;

  // Configuration registers
  logic [PLAYER_W-1:0] player_x;
  logic [PLAYER_W-1:0] player_y;
  logic [STEP_W-1:0]   max_steps;

  // March state
  dir_t             dx;
  dir_t             dy;
  pos_t             x;
  pos_t             y;
  logic [LEN_W-1:0] len;
  logic             oob;
  logic             timeout;
  face_t            last_face;

  // Clearing pass
  logic [ADDR_W-1:0] clr_cnt;

  // Output register
  logic              out_valid;
  logic [LEN_W-1:0]  out_length;
  face_t             out_face;
  logic [TEX_W-1:0]  out_tex;
  logic              out_timed_out;

  logic [ANGLE_W-1:0] angle_in;
  logic [ANGLE_W-1:0] cos_angle;
  pos_t               px;
  pos_t               py;
  pos_t               x_nxt;
  pos_t               y_nxt;
  pos_t               rd_x;
  pos_t               rd_y;
  cell_t              rd_col;
  cell_t              rd_row;
  logic               oob_rd;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  waddr;
  logic               we;
  logic [0:0]         wdata;
  logic [0:0]         rd_wall;
  logic               cell_in_range;

  pos_t             prev_x;
  pos_t             prev_y;
  cell_t            cc;
  cell_t            cr;
  cell_t            pc;
  cell_t            pr;
  face_t            hit_face;
  logic [TEX_W-1:0] hit_tex;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x  <= '0;
      player_y  <= '0;
      max_steps <= MAX_STEPS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PLAYER_X:  player_x  <= cfg.data[PLAYER_W-1:0];
        REG_PLAYER_Y:  player_y  <= cfg.data[PLAYER_W-1:0];
        REG_MAX_STEPS: max_steps <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Direction lookup and read address
  assign angle_in  = ANGLE_W'(ray_angle);
  assign cos_angle = angle_in + ANGLE_W'(QUARTER);
  assign px        = POS_W'(player_x);
  assign py        = POS_W'(player_y);
  assign x_nxt     = x + POS_W'(dx);
  assign y_nxt     = y + POS_W'(dy);
  assign rd_x      = cmd.start ? px : x_nxt;
  assign rd_y      = cmd.start ? py : y_nxt;
  assign rd_col    = cell_of(rd_x);
  assign rd_row    = cell_of(rd_y);
  assign oob_rd    = cell_oob(rd_col) || cell_oob(rd_row);
  assign raddr     = map_addr(rd_row[MAP_W-1:0], rd_col[MAP_W-1:0]);

  // Map writes: clearing pass, then cell loads
  assign cell_in_range = (cell_col < MAP_DIM) && (cell_row < MAP_DIM);
  assign we    = cmd.clear || (cmd.cell_write && cell_in_range);
  assign waddr = cmd.clear ? clr_cnt : map_addr(MAP_W'(cell_row), MAP_W'(cell_col));
  assign wdata = cmd.clear ? 1'b0 : cell_wall;

  grmwh_ram #(
    .WIDTH (1),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_wall)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dx      <= sin_lookup(cos_angle);
      dy      <= sin_lookup(angle_in);
      x       <= px;
      y       <= py;
      len     <= '0;
      oob     <= oob_rd;
      timeout <= 1'b0;
    end else if (cmd.step) begin
      x   <= x_nxt;
      y   <= y_nxt;
      len <= len + 1'b1;
      oob <= oob_rd;
    end
    if (cmd.set_timeout) begin
      timeout <= 1'b1;
    end
  end

  assign status.clear_done = (clr_cnt == ADDR_W'(MAP_CELLS - 1));
  assign status.blocked    = oob || rd_wall[0];
  assign status.at_limit   = (len >= max_steps);
  assign status.out_busy   = out_valid && !result.ready;

  // Face and texture column from the cell one step back
  assign prev_x = x - POS_W'(dx);
  assign prev_y = y - POS_W'(dy);
  assign cc     = cell_of(x);
  assign cr     = cell_of(y);
  assign pc     = cell_of(prev_x);
  assign pr     = cell_of(prev_y);

  always_comb begin
    if (pc == cc) begin
      hit_face = (pr < cr) ? FACE_SOUTH : FACE_NORTH;
      hit_tex  = TEX_W'(x[FRAC_BITS +: CELL_SHIFT]);
    end else begin
      hit_tex = TEX_W'(y[FRAC_BITS +: CELL_SHIFT]);
      if (pr == cr) begin
        hit_face = (pc < cc) ? FACE_EAST : FACE_WEST;
      end else begin
        // corner: keep the previous face
        hit_face = last_face;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_face <= FACE_NORTH;
    end else if (cmd.load_out && !timeout) begin
      last_face <= hit_face;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_length    <= len;
      out_timed_out <= timeout;
      out_face      <= timeout ? FACE_NORTH : hit_face;
      out_tex       <= timeout ? '0 : hit_tex;
    end
  end

  assign result.valid      = out_valid;
  assign result.ray_length = out_length;
  assign result.wall_face  = out_face;
  assign result.tex_column = out_tex;
  assign result.timed_out  = out_timed_out;

  `GRMWH_ASSERT_SAME(a_step_below_limit, clk, rst, cmd.step, len < max_steps, "step past limit")
  `GRMWH_ASSERT_NEXT(a_step_counts, clk, rst, cmd.step, len == $past(len) + 1'b1, "step lost")
  `GRMWH_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.load_out, !out_valid || result.ready, "result overwritten")
  `GRMWH_ASSERT_SAME(a_timeout_blank, clk, rst, out_valid && out_timed_out, out_face == FACE_NORTH && out_tex == '0, "timeout result not blank")

endmodule

// File: sv/grid_ray_march_wall_hit.sv
// Grid ray march with wall hit. Items on the item channel either load one map cell
// (no result) or cast one ray from the player position set through the configuration
// channel. A cast is accepted and its direction vector looked up, then the march tests
// for a stop before each step and once after the last, and then the face and texture
// column are formed; the march runs one step per cycle, paced by the single read port
// of the map RAM. The finished result sits in an output register, so the next item is
// taken while it waits; a cast only stalls in its finishing state if the previous
// result has not been taken yet. After reset all MAP_DIM * MAP_DIM map cells (4096 by
// default) are cleared before the first item is taken; configuration writes are taken
// at any time, and are meant for an idle block.
module grid_ray_march_wall_hit (
  input  logic        clk,
  input  logic        rst,
  grmwh_in_if.sink    item,
  grmwh_out_if.source result,
  grmwh_cfg_if.sink   cfg
);
  import grmwh_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;
  logic        in_ready;

  assign item.ready = in_ready;

  grmwh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_op    (item.operation),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  grmwh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cell_col  (item.cell_col),
    .cell_row  (item.cell_row),
    .cell_wall (item.cell_wall),
    .ray_angle (item.ray_angle),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

// File: sim/grid_ray_march_wall_hit_test.sv
`timescale 1ns / 1ps

module grid_ray_march_wall_hit_test;
  import grmwh_pkg::*;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam int CELL_POS_SHIFT = FRAC_BITS + CELL_SHIFT;
  localparam int ITEM_TARGET    = 1300;
  localparam int REPORT_LIMIT   = 10;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_AFTER     = 40;
  localparam int HOLD_CYCLES    = 1500;
  localparam logic [PLAYER_W-1:0] POS_MAX = '1;
  // Index past the last register; writes there are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    face_t            face;
    logic [TEX_W-1:0] tex;
    logic             timed_out;
  } ray_hit_t;

  class ray_hit_tracker;
    logic [PLAYER_W-1:0] start_x;
    logic [PLAYER_W-1:0] start_y;
    logic [STEP_W-1:0]   step_limit;
    bit                  wall_at [MAP_CELLS];
    face_t               prior_face;
    int                  sine_q14 [QUARTER + 1];
    ray_hit_t            pending_hits [$];
    int unsigned         errors;

    function new();
      start_x    = '0;
      start_y    = '0;
      step_limit = MAX_STEPS_RESET;
      prior_face = FACE_NORTH;
      errors     = 0;
      foreach (wall_at[i]) wall_at[i] = 1'b0;
      for (int r = 0; r <= QUARTER; r++) sine_q14[r] = quadrant_sine(r);
    endfunction

    // Taylor series to x^13 in Q2.30, rounded half up to Q1.14
    function int quadrant_sine(int unsigned r);
      longint unsigned ang, t, acc;
      ang = (longint'(r) * TWO_PI_Q30) / ANGLE_STEPS;
      t   = ang;
      acc = ang;
      for (int k = 1; k <= 6; k++) begin
        t = (t * ang) >> 30;
        t = (t * ang) >> 30;
        t = t / (2 * k * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = (acc >= t) ? acc - t : 0;
        end else begin
          acc = acc + t;
        end
      end
      acc = (acc + (1 << 15)) >> 16;
      if (acc > (1 << FRAC_BITS)) acc = 1 << FRAC_BITS;
      return int'(acc);
    endfunction

    function longint direction(int a);
      int v;
      v = a % ANGLE_STEPS;
      if (v < QUARTER) return sine_q14[v];
      if (v < 2 * QUARTER) return sine_q14[2 * QUARTER - v];
      if (v < 3 * QUARTER) return -sine_q14[v - 2 * QUARTER];
      return -sine_q14[4 * QUARTER - v];
    endfunction

    function bit is_blocked(longint col, longint row);
      if (col < 0 || row < 0 || col >= MAP_DIM || row >= MAP_DIM) return 1'b1;
      return wall_at[row * MAP_DIM + col];
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PLAYER_X:  start_x = value[PLAYER_W-1:0];
        REG_PLAYER_Y:  start_y = value[PLAYER_W-1:0];
        REG_MAX_STEPS: step_limit = value[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function void march(logic [ANGLE_IN_W-1:0] angle);
      longint      dx, dy, px, py, cc, cr, pc, pr, along;
      int unsigned steps;
      ray_hit_t    h;
      dx    = direction(int'(angle) + QUARTER);
      dy    = direction(int'(angle));
      px    = longint'(start_x);
      py    = longint'(start_y);
      steps = 0;
      while (!is_blocked(px >>> CELL_POS_SHIFT, py >>> CELL_POS_SHIFT)) begin
        if (steps >= step_limit) begin
          h.length    = LEN_W'(steps);
          h.face      = FACE_NORTH;
          h.tex       = '0;
          h.timed_out = 1'b1;
          pending_hits.push_back(h);
          return;
        end
        px += dx;
        py += dy;
        steps++;
      end
      cc = px >>> CELL_POS_SHIFT;
      cr = py >>> CELL_POS_SHIFT;
      pc = (px - dx) >>> CELL_POS_SHIFT;
      pr = (py - dy) >>> CELL_POS_SHIFT;
      if (pc == cc) begin
        h.face = (pr < cr) ? FACE_SOUTH : FACE_NORTH;
        along  = px >>> FRAC_BITS;
      end else begin
        // both row and column changed: corner, keep the previous face
        if (pr == cr) h.face = (pc < cc) ? FACE_EAST : FACE_WEST;
        else h.face = prior_face;
        along = py >>> FRAC_BITS;
      end
      prior_face  = h.face;
      h.length    = LEN_W'(steps);
      h.tex       = TEX_W'(along);
      h.timed_out = 1'b0;
      pending_hits.push_back(h);
    endfunction

    function void note_item(op_t op, logic [CELL_IDX_W-1:0] col, logic [CELL_IDX_W-1:0] row,
                            logic wall, logic [ANGLE_IN_W-1:0] angle);
      if (op == OP_WRITE_CELL) wall_at[int'(row) * MAP_DIM + int'(col)] = wall;
      else march(angle);
    endfunction

    function void check_result(logic [LEN_W-1:0] len, logic [FACE_W-1:0] face,
                               logic [TEX_W-1:0] tex, logic tout);
      ray_hit_t got, want;
      got.length    = len;
      got.face      = face_t'(face);
      got.tex       = tex;
      got.timed_out = tout;
      if (pending_hits.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected ray result: len %0d face %0d tex %0d timeout %0b",
                   len, face, tex, tout);
        return;
      end
      want = pending_hits.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ray result mismatch: expected len %0d face %0d tex %0d timeout %0b, %s",
                   want.length, want.face, want.tex, want.timed_out,
                   $sformatf("got len %0d face %0d tex %0d timeout %0b",
                             len, face, tex, tout));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  grmwh_in_if  item_ch ();
  grmwh_out_if hit_ch ();
  grmwh_cfg_if cfg_ch ();

  grid_ray_march_wall_hit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (hit_ch),
    .cfg    (cfg_ch)
  );

  ray_hit_tracker tracker = new();
  int unsigned    send_idle_pct = 8;
  int unsigned    recv_idle_pct = 79;
  int unsigned    items_sent = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        tracker.note_item(op_t'(item_ch.operation), item_ch.cell_col, item_ch.cell_row,
                          item_ch.cell_wall, item_ch.ray_angle);
      if (cfg_ch.valid && cfg_ch.ready)
        tracker.set_register(cfg_ch.index, cfg_ch.data);
      if (hit_ch.valid && hit_ch.ready)
        tracker.check_result(hit_ch.ray_length, hit_ch.wall_face, hit_ch.tex_column,
                             hit_ch.timed_out);
    end
  end

  // Result side: random back-pressure, plus one long hold-off to fill the block
  initial begin : receiver
    int unsigned taken;
    int unsigned hold_left;
    taken     = 0;
    hold_left = 0;
    hit_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hit_ch.valid && hit_ch.ready) begin
        taken++;
        if (taken == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        hit_ch.ready <= 1'b0;
      end else begin
        hit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #120_000_000;
    $display("grid_ray_march_wall_hit_test: done, errors");
    $finish;
  end

  task automatic offer_item(op_t op, logic [CELL_IDX_W-1:0] col, logic [CELL_IDX_W-1:0] row,
                            logic wall, logic [ANGLE_IN_W-1:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.cell_col  <= col;
    item_ch.cell_row  <= row;
    item_ch.cell_wall <= wall;
    item_ch.ray_angle <= angle;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_cast(int angle);
    offer_item(OP_CAST, CELL_IDX_W'($urandom()), CELL_IDX_W'($urandom()), 1'($urandom()),
               ANGLE_IN_W'(angle));
  endtask

  task automatic send_cell(int col, int row, logic wall);
    offer_item(OP_WRITE_CELL, CELL_IDX_W'(col), CELL_IDX_W'(row), wall,
               ANGLE_IN_W'($urandom()));
  endtask

  // Hold the item channel until every cast has come back, then let writes settle
  task automatic drain_hits();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(logic [PLAYER_W-1:0] x, logic [PLAYER_W-1:0] y,
                                   logic [STEP_W-1:0] limit);
    logic [CFG_DATA_W-1:0] value [1 << CFG_IDX_W];
    value[REG_PLAYER_X]  = x;
    value[REG_PLAYER_Y]  = y;
    value[REG_MAX_STEPS] = {(CFG_DATA_W - STEP_W)'($urandom()), limit};
    value[REG_SPARE]     = CFG_DATA_W'($urandom());
    for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CFG_IDX_W'(i);
      cfg_ch.data  <= value[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned         phase;
    int unsigned         count;
    int unsigned         pick;
    int                  col, row, home_col, home_row;
    logic [PLAYER_W-1:0] px, py;
    logic [STEP_W-1:0]   limit;
    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.operation = OP_WRITE_CELL;
    item_ch.cell_col  = '0;
    item_ch.cell_row  = '0;
    item_ch.cell_wall = 1'b0;
    item_ch.ray_angle = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // From the origin on an empty map, limit at its reset value
    send_cast(0);
    send_cast(3 * QUARTER);
    send_cast(QUARTER / 2);
    send_cast(2 * QUARTER);
    send_cell(1, 0, 1'b1);
    send_cast(0);
    send_cell(0, 1, 1'b1);
    send_cast(QUARTER);
    // diagonal into a wall corner
    send_cell(1, 1, 1'b1);
    send_cast(QUARTER / 2);
    // start inside a wall
    send_cell(0, 0, 1'b1);
    send_cast(300);
    send_cell(0, 0, 1'b0);
    drain_hits();

    program_registers('0, '0, 16'd1);
    send_cast(0);
    drain_hits();

    program_registers(POS_MAX, POS_MAX, 16'hFFFF);
    send_cell(MAP_DIM - 1, MAP_DIM - 1, 1'b1);
    send_cast(0);
    send_cell(MAP_DIM - 1, MAP_DIM - 1, 1'b0);
    send_cast(0);
    send_cast(QUARTER);
    drain_hits();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 79;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      home_col = $urandom_range(MAP_DIM - 1);
      home_row = $urandom_range(MAP_DIM - 1);
      px = {CELL_IDX_W'(home_col), (PLAYER_W - CELL_IDX_W)'($urandom())};
      py = {CELL_IDX_W'(home_row), (PLAYER_W - CELL_IDX_W)'($urandom())};
      if (phase % 8 == 2) begin
        px = '0;
        py = POS_MAX;
      end else if (phase % 8 == 3) begin
        px = POS_MAX;
        py = '0;
      end
      home_col = int'(px >> (PLAYER_W - CELL_IDX_W));
      home_row = int'(py >> (PLAYER_W - CELL_IDX_W));
      // long rays are costly: keep the open-ended phases short
      if (phase % 8 == 0) begin
        limit = 16'hFFFF;
        count = 20;
      end else if (phase % 8 == 1) begin
        limit = STEP_W'($urandom_range(8, 1));
        count = $urandom_range(80, 40);
      end else begin
        limit = STEP_W'($urandom_range(600, 16));
        count = $urandom_range(90, 40);
      end
      program_registers(px, py, limit);
      repeat (count) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          // walls around the start cell keep the rays short
          col = home_col + int'($urandom_range(10)) - 5;
          row = home_row + int'($urandom_range(10)) - 5;
          if (col < 0) col = 0;
          if (col > MAP_DIM - 1) col = MAP_DIM - 1;
          if (row < 0) row = 0;
          if (row > MAP_DIM - 1) row = MAP_DIM - 1;
          send_cell(col, row, $urandom_range(9) < 7);
        end else if (pick < 40) begin
          send_cell($urandom_range(MAP_DIM - 1), $urandom_range(MAP_DIM - 1),
                    1'($urandom()));
        end else if ($urandom_range(9) == 0) begin
          send_cast(QUARTER * $urandom_range(3));
        end else begin
          send_cast($urandom_range(ANGLE_STEPS - 1));
        end
        if ($urandom_range(199) == 0) drain_hits();
      end
      drain_hits();
      phase++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_hits.size() == 0) begin
      $display("grid_ray_march_wall_hit_test: done, clean");
    end else begin
      $display("grid_ray_march_wall_hit_test: done, errors");
    end
    $finish;
  end

endmodule
